[sv/jdc_pkg.sv]
// ----------------------------------------------------------------------------
// jdc_pkg
// shared types and constants for the joystick drive and cursor block
// ----------------------------------------------------------------------------
`default_nettype none

package jdc_pkg;

	localparam int unsigned SAMPLE_W  = 8;
	localparam int unsigned SPEED_W   = 8;
	localparam int unsigned DIV_W     = 2;
	localparam int unsigned CURSOR_W  = 6;

	// axis snapping
	localparam logic [SAMPLE_W-1:0] SNAP_LO     = 8'd8;
	localparam logic [SAMPLE_W-1:0] SNAP_HI     = 8'd248;
	localparam logic [SAMPLE_W-1:0] SNAP_CTR_LO = 8'd120;
	localparam logic [SAMPLE_W-1:0] SNAP_CTR_HI = 8'd136;
	localparam logic [SAMPLE_W-1:0] AXIS_CTR    = 8'd128;
	localparam logic [SAMPLE_W-1:0] AXIS_MAX    = 8'd255;

	// navigation centre band
	localparam logic [SAMPLE_W-1:0] NAV_LO = 8'd64;
	localparam logic [SAMPLE_W-1:0] NAV_HI = 8'd192;

	// cursor grid: 3 rows by 16 columns
	localparam logic [CURSOR_W:0] ROW_STEP   = 7'd16;
	localparam logic [CURSOR_W:0] GRID_CELLS = 7'd48;

	localparam logic [DIV_W-1:0] DIV_ONE = 2'd1;
	localparam logic [DIV_W-1:0] DIV_MAX = 2'd3;

	typedef struct packed {
		logic up;
		logic down;
		logic left;
		logic right;
	} jdc_moves_t;

	// a zero divisor is treated as one
	function automatic logic [DIV_W-1:0] eff_div(input logic [DIV_W-1:0] d);
		eff_div = (d == '0) ? DIV_ONE : d;
	endfunction

endpackage

`default_nettype wire

[sv/jdc_mix.sv]
// ----------------------------------------------------------------------------
// jdc_mix
// axis snapping, arcade mixing, saturation and deadband
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_mix (
	input  wire logic        [jdc_pkg::SAMPLE_W-1:0] vert,
	input  wire logic        [jdc_pkg::SAMPLE_W-1:0] horz,
	output      logic signed [jdc_pkg::SPEED_W-1:0]  left_mix,
	output      logic signed [jdc_pkg::SPEED_W-1:0]  right_mix
);
	import jdc_pkg::*;

	function automatic logic [SAMPLE_W-1:0] snap(input logic [SAMPLE_W-1:0] a);
		priority if (a < SNAP_LO)                       snap = '0;
		else if (a > SNAP_HI)                           snap = AXIS_MAX;
		else if ((a > SNAP_CTR_LO) && (a < SNAP_CTR_HI)) snap = AXIS_CTR;
		else                                            snap = a;
	endfunction

	function automatic logic signed [SPEED_W-1:0] shape(input logic signed [9:0] s);
		priority if (s < -10'sd127)                         shape = -8'sd127;
		else if (s > 10'sd127)                              shape = 8'sd127;
		else if ((s > -10'sd2) && (s < 10'sd2))             shape = '0;
		else                                                shape = s[SPEED_W-1:0];
	endfunction

	logic [SAMPLE_W-1:0] v_snap;
	logic [SAMPLE_W-1:0] h_snap;
	logic signed [9:0]   left_raw;
	logic signed [9:0]   right_raw;

	always_comb begin
		v_snap    = snap(vert);
		h_snap    = snap(horz);
		left_raw  = $signed({2'b00, v_snap}) - $signed({2'b00, h_snap});
		// v + h - 256
		right_raw = $signed({2'b00, v_snap}) + $signed({2'b00, h_snap}) - 10'sd256;
		left_mix  = shape(left_raw);
		right_mix = shape(right_raw);
	end

endmodule

`default_nettype wire

[sv/jdc_div.sv]
// ----------------------------------------------------------------------------
// jdc_div
// shared radix-4 restoring divider for the wheel speeds, truncates to zero
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [jdc_pkg::SPEED_W-1:0] dividend,
	input  wire logic        [jdc_pkg::DIV_W-1:0]   divisor,
	output      logic                               done,
	output      logic signed [jdc_pkg::SPEED_W-1:0] quotient
);
	import jdc_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [1:0]          cnt_q;
	logic                neg_q;
	logic [DIV_W-1:0]    dvs_q;
	logic [SPEED_W-1:0]  num_q;
	logic [SPEED_W-1:0]  quo_q;
	logic [1:0]          rem_q;

	logic [3:0] part;
	logic [3:0] d1;
	logic [3:0] d2;
	logic [3:0] d3;
	logic [1:0] digit;
	logic [3:0] rem_next;

	always_comb begin
		part = {rem_q, num_q[SPEED_W-1 -: 2]};
		d1   = {2'b00, dvs_q};
		d2   = {1'b0, dvs_q, 1'b0};
		d3   = d1 + d2;
		priority if (part >= d3) begin
			digit    = 2'd3;
			rem_next = part - d3;
		end else if (part >= d2) begin
			digit    = 2'd2;
			rem_next = part - d2;
		end else if (part >= d1) begin
			digit    = 2'd1;
			rem_next = part - d1;
		end else begin
			digit    = 2'd0;
			rem_next = part;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SPEED_W-1];
			num_q <= dividend[SPEED_W-1] ? SPEED_W'(-dividend) : dividend;
			dvs_q <= divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SPEED_W-3:0], 2'b00};
			quo_q <= {quo_q[SPEED_W-3:0], digit};
			rem_q <= rem_next[1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? SPEED_W'(-quo_q) : quo_q;

endmodule

`default_nettype wire

[sv/jdc_nav.sv]
// ----------------------------------------------------------------------------
// jdc_nav
// centre-return hysteresis and wrapping cursor on a 3 by 16 grid
// ----------------------------------------------------------------------------
`default_nettype none

module jdc_nav (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            update,
	input  wire logic                            clear,
	input  wire logic [jdc_pkg::SAMPLE_W-1:0]    vert,
	input  wire logic [jdc_pkg::SAMPLE_W-1:0]    horz,
	output      jdc_pkg::jdc_moves_t             moves,
	output      logic [jdc_pkg::CURSOR_W-1:0]    cursor
);
	import jdc_pkg::*;

	logic                vert_cent_q;
	logic                horz_cent_q;
	logic [CURSOR_W-1:0] cursor_q;
	jdc_moves_t          moves_q;

	logic                v_in_band;
	logic                h_in_band;
	logic                v_fire;
	logic                h_fire;
	logic [CURSOR_W:0]   c_mid;
	logic [CURSOR_W:0]   c_end;
	jdc_moves_t          moves_d;

	always_comb begin
		v_in_band = (vert > NAV_LO) && (vert < NAV_HI);
		h_in_band = (horz > NAV_LO) && (horz < NAV_HI);
		v_fire    = !v_in_band && vert_cent_q;
		h_fire    = !h_in_band && horz_cent_q;
		moves_d   = '0;
		c_mid     = {1'b0, cursor_q};
		if (v_fire) begin
			if (vert > AXIS_CTR) begin
				moves_d.up = 1'b1;
				c_mid = (c_mid < ROW_STEP) ? c_mid + (GRID_CELLS - ROW_STEP) : c_mid - ROW_STEP;
			end else begin
				moves_d.down = 1'b1;
				c_mid = c_mid + ROW_STEP;
				if (c_mid > GRID_CELLS - 7'd1) begin
					c_mid = c_mid - GRID_CELLS;
				end
			end
		end
		c_end = c_mid;
		if (h_fire) begin
			if (horz > AXIS_CTR) begin
				moves_d.left = 1'b1;
				// column 0 wraps to column 15 of the same row
				if (c_end[3:0] == 4'd0 && c_end[CURSOR_W:4] < 3'd3) begin
					c_end = c_end + ROW_STEP;
				end
				c_end = c_end - 7'd1;
			end else begin
				moves_d.right = 1'b1;
				c_end = c_end + 7'd1;
				if (c_end == 7'd16 || c_end == 7'd32 || c_end == 7'd48) begin
					c_end = c_end - ROW_STEP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_cent_q <= 1'b0;
			horz_cent_q <= 1'b0;
			cursor_q    <= '0;
			moves_q     <= '0;
		end else if (update) begin
			vert_cent_q <= v_in_band;
			horz_cent_q <= h_in_band;
			cursor_q    <= c_end[CURSOR_W-1:0];
			moves_q     <= moves_d;
		end else if (clear) begin
			moves_q <= '0;
		end
	end

	assign moves  = moves_q;
	assign cursor = cursor_q;

endmodule

`default_nettype wire

[sv/joystick_drive_and_cursor.sv]
// ----------------------------------------------------------------------------
// joystick_drive_and_cursor
// joystick mixer for a two-wheel drive plus a menu cursor
// ----------------------------------------------------------------------------
// one request on s_axis carries a vertical and a horizontal sample in tdata and
// the drive-mode and speed-button flags in tuser. each request yields exactly
// one result on m_axis: both wheel speeds, the speed divisor, four navigation
// events and the cursor index.
// in drive mode the samples are snapped and mixed in the accept cycle, then a
// shared radix-4 divider takes the left and then the right speed, four steps
// each with a handoff between; the result register loads from ST_OUT once
// both quotients are in, and s_axis_tready stays low until then, so a drive
// request is not taken before the last result has loaded.
// a navigation request updates the cursor at accept and needs no division: the
// result register loads from ST_OUT after accept; s_axis_tready stays low until then.
// the result sits in an output register, so a stalled m_axis holds the result
// while the next request is already accepted; a further one waits for the slot.
// reset sets the divisor to 1, the cursor to 0 and clears both centre flags.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_drive_and_cursor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // vert_sample, horz_sample
	input  wire logic [1:0]  s_axis_tuser,  // drive_mode, speed_step
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// left_speed, right_speed, speed_divisor, move_up, move_down, move_left,
	// move_right, cursor_position, zero fill
	output      logic [31:0] m_axis_tdata
);
	import jdc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIVL = 4'b0010,
		ST_DIVR = 4'b0100,
		ST_OUT  = 4'b1000
	} jdc_state_t;

	jdc_state_t state_q;

	logic [SAMPLE_W-1:0]        vert;
	logic [SAMPLE_W-1:0]        horz;
	logic                       drive;
	logic                       step;
	logic                       accept;
	logic [DIV_W-1:0]           div_q;
	logic [DIV_W-1:0]           div_next;
	logic signed [SPEED_W-1:0]  left_mix;
	logic signed [SPEED_W-1:0]  right_mix;
	logic signed [SPEED_W-1:0]  lspd_q;
	logic signed [SPEED_W-1:0]  rspd_q;
	logic                       dv_start;
	logic signed [SPEED_W-1:0]  dv_operand;
	logic [DIV_W-1:0]           dv_divisor;
	logic                       dv_done;
	logic signed [SPEED_W-1:0]  dv_quot;
	jdc_moves_t                 moves;
	logic [CURSOR_W-1:0]        cursor;
	logic                       out_free;
	logic                       m_valid_q;
	logic [31:0]                m_data_q;

	assign vert   = s_axis_tdata[7:0];
	assign horz   = s_axis_tdata[15:8];
	assign drive  = s_axis_tuser[0];
	assign step   = s_axis_tuser[1];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		div_next = div_q;
		if (drive && step) begin
			div_next = (div_q == DIV_MAX || div_q == '0) ? DIV_ONE : div_q + DIV_ONE;
		end
	end

	jdc_mix u_mix (
		.vert      (vert),
		.horz      (horz),
		.left_mix  (left_mix),
		.right_mix (right_mix)
	);

	assign dv_start   = (accept && drive) || (state_q == ST_DIVL && dv_done);
	assign dv_operand = (state_q == ST_IDLE) ? left_mix : rspd_q;
	assign dv_divisor = (state_q == ST_IDLE) ? eff_div(div_next) : eff_div(div_q);

	jdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_operand),
		.divisor  (dv_divisor),
		.done     (dv_done),
		.quotient (dv_quot)
	);

	jdc_nav u_nav (
		.clk    (clk),
		.arst_n (arst_n),
		.update (accept && !drive),
		.clear  (accept && drive),
		.vert   (vert),
		.horz   (horz),
		.moves  (moves),
		.cursor (cursor)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_q     <= DIV_ONE;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						div_q   <= div_next;
						state_q <= drive ? ST_DIVL : ST_OUT;
					end
				end
				ST_DIVL: begin
					if (dv_done) begin
						state_q <= ST_DIVR;
					end
				end
				ST_DIVR: begin
					if (dv_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lspd_q <= drive ? left_mix : '0;
			rspd_q <= drive ? right_mix : '0;
		end else if (state_q == ST_DIVL && dv_done) begin
			lspd_q <= dv_quot;
		end else if (state_q == ST_DIVR && dv_done) begin
			rspd_q <= dv_quot;
		end
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= {4'b0000, cursor, moves.right, moves.left, moves.down, moves.up,
				div_q, rspd_q, lspd_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the joystick drive mixer and menu cursor
// ----------------------------------------------------------------------------
// a queue of joystick requests feeds a clocked driver on s_axis; every accepted
// request is run through a local model of the mixer, divisor and cursor, and
// the outcome is queued. a clocked monitor on m_axis compares each result
// field by field with the oldest queued outcome. both sides idle at random,
// the sink holds off once for a long stretch, and the source drains between
// phases.
// ----------------------------------------------------------------------------

module tb_top;
	import jdc_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_ITEMS   = 650;
	localparam int TAIL_CYCLES  = 30;
	localparam int LONG_HOLD_AT = 300;
	localparam int LONG_HOLD    = 200;
	localparam int SPEED_MAX    = 127;
	localparam int DEADBAND     = 2;
	localparam int MIX_OFFSET   = 256;

	typedef struct packed {
		logic [SAMPLE_W-1:0] vert;
		logic [SAMPLE_W-1:0] horz;
		logic                drive;
		logic                step;
	} joy_sample_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic [DIV_W-1:0]          divisor;
		jdc_moves_t                moves;
		logic [CURSOR_W-1:0]       cursor;
	} wheel_cursor_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // vert_sample, horz_sample
	logic [1:0]  s_axis_tuser = '0;   // drive_mode, speed_step
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// left_speed, right_speed, speed_divisor, move_up, move_down, move_left,
	// move_right, cursor_position, zero fill
	logic [31:0] m_axis_tdata;

	joystick_drive_and_cursor uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// model state
	logic [DIV_W-1:0]    div_st = DIV_ONE;
	logic                vert_ctr_st = 1'b0;
	logic                horz_ctr_st = 1'b0;
	logic [CURSOR_W-1:0] cursor_st = '0;

	joy_sample_t   sample_q[$];
	wheel_cursor_t wheel_cursor_q[$];
	joy_sample_t   cur_sample = '0;

	int  n_queued = 0;
	int  n_accepted = 0;
	int  n_results = 0;
	int  n_errors = 0;
	int  cycle_cnt = 0;
	bit  in_fire = 1'b0;
	bit  out_fire = 1'b0;
	bit  drv_busy = 1'b0;
	int  drv_gap = 0;
	int  sink_stall = 0;

	function automatic int snap_axis(int a);
		if (a < int'(SNAP_LO))
			return 0;
		if (a > int'(SNAP_HI))
			return int'(AXIS_MAX);
		if (a > int'(SNAP_CTR_LO) && a < int'(SNAP_CTR_HI))
			return int'(AXIS_CTR);
		return a;
	endfunction

	function automatic int shape_speed(int s, int dv);
		if (s < -SPEED_MAX)
			s = -SPEED_MAX;
		else if (s > SPEED_MAX)
			s = SPEED_MAX;
		else if (s > -DEADBAND && s < DEADBAND)
			s = 0;
		return s / dv;
	endfunction

	function automatic wheel_cursor_t predict_wheel_cursor(joy_sample_t s);
		wheel_cursor_t r;
		int v;
		int h;
		int c;
		int dv;
		r = '0;
		v = s.vert;
		h = s.horz;
		c = cursor_st;
		if (s.drive) begin
			if (s.step)
				div_st = (div_st == DIV_MAX) ? DIV_ONE : div_st + 1'b1;
			dv = (div_st == '0) ? 1 : int'(div_st);
			v = snap_axis(v);
			h = snap_axis(h);
			r.left_speed  = SPEED_W'(shape_speed(v - h, dv));
			r.right_speed = SPEED_W'(shape_speed(v + h - MIX_OFFSET, dv));
		end else begin
			if (v > int'(NAV_LO) && v < int'(NAV_HI)) begin
				vert_ctr_st = 1'b1;
			end else if (vert_ctr_st) begin
				vert_ctr_st = 1'b0;
				if (v > int'(AXIS_CTR)) begin
					if (c < int'(ROW_STEP))
						c += int'(GRID_CELLS);
					c -= int'(ROW_STEP);
					r.moves.up = 1'b1;
				end else begin
					c += int'(ROW_STEP);
					if (c >= int'(GRID_CELLS))
						c -= int'(GRID_CELLS);
					r.moves.down = 1'b1;
				end
			end
			// horizontal acts on the cursor already moved vertically
			if (h > int'(NAV_LO) && h < int'(NAV_HI)) begin
				horz_ctr_st = 1'b1;
			end else if (horz_ctr_st) begin
				horz_ctr_st = 1'b0;
				if (h > int'(AXIS_CTR)) begin
					if (c == 0 || c == 16 || c == 32)
						c += int'(ROW_STEP);
					c -= 1;
					r.moves.left = 1'b1;
				end else begin
					c += 1;
					if (c == 16 || c == 32 || c == 48)
						c -= int'(ROW_STEP);
					r.moves.right = 1'b1;
				end
			end
			cursor_st = CURSOR_W'(c);
		end
		r.divisor = div_st;
		r.cursor  = cursor_st;
		return r;
	endfunction

	task automatic cmp_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
			n_errors++;
		end
	endtask

	// input side: capture accepted requests
	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				wheel_cursor_q.push_back(predict_wheel_cursor(cur_sample));
				n_accepted++;
			end
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire) begin
				drv_busy = 1'b0;
				// every fourth block of 40 requests runs back to back
				drv_gap = ((n_accepted / 40) % 4 == 3) ? 0 : $urandom_range(0, 3);
			end
			if (!drv_busy) begin
				if (drv_gap > 0) begin
					drv_gap--;
				end else if (sample_q.size() > 0) begin
					cur_sample = sample_q.pop_front();
					drv_busy = 1'b1;
				end
			end
			s_axis_tvalid <= drv_busy;
			s_axis_tdata  <= {cur_sample.horz, cur_sample.vert};
			s_axis_tuser  <= {cur_sample.step, cur_sample.drive};
		end
	end

	// sink ready, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire) begin
				if (n_results == LONG_HOLD_AT)
					sink_stall = LONG_HOLD;
				else
					sink_stall = ((n_results / 50) % 3 == 2) ? 0 : $urandom_range(0, 3);
			end
			if (sink_stall > 0) begin
				sink_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		wheel_cursor_t exp_r;
		if (!arst_n) begin
			out_fire <= 1'b0;
		end else begin
			out_fire <= m_axis_tvalid && m_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				if (wheel_cursor_q.size() == 0) begin
					$error("result 0x%08h arrived with no request outstanding", m_axis_tdata);
					n_errors++;
				end else begin
					exp_r = wheel_cursor_q.pop_front();
					cmp_field("left_speed", exp_r.left_speed, $signed(m_axis_tdata[7:0]));
					cmp_field("right_speed", exp_r.right_speed, $signed(m_axis_tdata[15:8]));
					cmp_field("speed_divisor", exp_r.divisor, m_axis_tdata[17:16]);
					cmp_field("move_up", exp_r.moves.up, m_axis_tdata[18]);
					cmp_field("move_down", exp_r.moves.down, m_axis_tdata[19]);
					cmp_field("move_left", exp_r.moves.left, m_axis_tdata[20]);
					cmp_field("move_right", exp_r.moves.right, m_axis_tdata[21]);
					cmp_field("cursor_position", exp_r.cursor, m_axis_tdata[27:22]);
					cmp_field("zero_fill", 0, m_axis_tdata[31:28]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic add_sample(int v, int h, bit drive, bit step);
		joy_sample_t s;
		s.vert  = SAMPLE_W'(v);
		s.horz  = SAMPLE_W'(h);
		s.drive = drive;
		s.step  = step;
		sample_q.push_back(s);
		n_queued++;
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || wheel_cursor_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_axis();
		int edges[15] = '{0, 7, 8, 9, 119, 120, 121, 128, 135, 136, 137, 247, 248, 249, 255};
		if ($urandom_range(0, 3) == 0)
			return edges[$urandom_range(0, 14)];
		return $urandom_range(0, 255);
	endfunction

	function automatic int in_band();
		return $urandom_range(65, 191);
	endfunction

	function automatic int out_band();
		return $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(192, 255);
	endfunction

	task automatic add_random(int count);
		int target;
		int axes;
		target = n_queued + count;
		while (n_queued < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					add_sample(pick_axis(), pick_axis(), 1'b1, $urandom_range(0, 3) == 0);
				end
				4, 5, 6, 7: begin
					// centre, then leave the band on one or both axes
					axes = $urandom_range(1, 3);
					add_sample(in_band(), in_band(), 1'b0, $urandom_range(0, 1));
					add_sample(axes[0] ? out_band() : in_band(),
						axes[1] ? out_band() : in_band(), 1'b0, $urandom_range(0, 1));
				end
				default: begin
					add_sample($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 1), $urandom_range(0, 1));
				end
			endcase
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drive mode: extremes, snap edges, deadband, divisor steps
		add_sample(128, 128, 1'b1, 1'b0);
		add_sample(0, 0, 1'b1, 1'b1);
		add_sample(255, 255, 1'b1, 1'b1);
		add_sample(0, 255, 1'b1, 1'b0);
		add_sample(255, 0, 1'b1, 1'b1);
		add_sample(7, 8, 1'b1, 1'b0);
		add_sample(248, 249, 1'b1, 1'b0);
		add_sample(121, 135, 1'b1, 1'b0);
		add_sample(120, 136, 1'b1, 1'b0);
		add_sample(150, 149, 1'b1, 1'b0);
		add_sample(150, 107, 1'b1, 1'b0);
		add_sample(130, 255, 1'b1, 1'b1);
		// navigation: events, wraps, band edges, both axes at once
		add_sample(128, 128, 1'b0, 1'b1);
		add_sample(255, 128, 1'b0, 1'b0);
		add_sample(128, 128, 1'b0, 1'b0);
		add_sample(0, 128, 1'b0, 1'b0);
		add_sample(64, 128, 1'b0, 1'b0);
		add_sample(65, 191, 1'b0, 1'b0);
		add_sample(192, 192, 1'b0, 1'b0);
		add_sample(191, 65, 1'b0, 1'b0);
		add_sample(0, 0, 1'b0, 1'b0);
		add_sample(128, 128, 1'b0, 1'b0);
		add_sample(128, 0, 1'b0, 1'b0);
		add_sample(100, 255, 1'b1, 1'b1);
		wait_drained();

		add_random(RAND_ITEMS / 2);
		wait_drained();
		add_random(RAND_ITEMS - RAND_ITEMS / 2);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0 && wheel_cursor_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
